// File: rtl/core/cc20_pkg.sv
// Shared types, constants and round functions for the ChaCha20 stream XOR block.
`default_nettype none
package cc20_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_message;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [63:0] key2;
    logic [63:0] key3;
    logic [63:0] nonce0;
    logic [31:0] nonce1;
    logic [31:0] start_counter;
  } cfg_t;

  localparam int unsigned CFG_DATA_W = 64;
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_KEY0   = 3'd0;
  localparam reg_idx_t REG_KEY1   = 3'd1;
  localparam reg_idx_t REG_KEY2   = 3'd2;
  localparam reg_idx_t REG_KEY3   = 3'd3;
  localparam reg_idx_t REG_NONCE0 = 3'd4;
  localparam reg_idx_t REG_NONCE1 = 3'd5;
  localparam reg_idx_t REG_START  = 3'd6;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] cc_state_t;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned HALF_STEPS    = DOUBLE_ROUNDS * 4;
  localparam int unsigned STEP_W        = $clog2(HALF_STEPS);
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t LAST_STEP = step_t'(HALF_STEPS - 1);

  typedef logic [5:0] byte_pos_t;
  localparam byte_pos_t LAST_POS = 6'd63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // Half a quarter round: rotations 16/12, or 8/7 when second is set.
  function automatic quad_t qr_half(quad_t q, logic second);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    quad_t       r;
    a = q.a + q.b;
    d = q.d ^ a;
    d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
    c = q.c + d;
    b = q.b ^ c;
    b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    return r;
  endfunction

  function automatic cc_state_t init_state(cfg_t cfg, logic [31:0] cnt);
    cc_state_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = cfg.key0[31:0];
    s[5]  = cfg.key0[63:32];
    s[6]  = cfg.key1[31:0];
    s[7]  = cfg.key1[63:32];
    s[8]  = cfg.key2[31:0];
    s[9]  = cfg.key2[63:32];
    s[10] = cfg.key3[31:0];
    s[11] = cfg.key3[63:32];
    s[12] = cnt;
    s[13] = cfg.nonce0[31:0];
    s[14] = cfg.nonce0[63:32];
    s[15] = cfg.nonce1;
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/cc20_front.sv
// Front end: accepts input items into a short queue read by the keystream engine.
`default_nettype none
module cc20_front import cc20_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire in_item_t item,
  output logic          head_valid,
  output in_item_t      head,
  input  wire logic     pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  in_item_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               do_pop;

  assign item_stall = (count == CNT_W'(DEPTH));
  assign push       = item_valid && !item_stall;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/cc20_back.sv
// Back end: ChaCha20 block engine, keystream position tracking and output register.
`default_nettype none
module cc20_back import cc20_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     head_valid,
  input  wire in_item_t head,
  output logic          pop,
  output logic          result_valid,
  input  wire logic     result_stall,
  output out_item_t     result
);

  back_state_t state;
  back_state_t state_next;
  step_t       step;
  step_t       step_next;
  cc_state_t   work;
  cc_state_t   work_next;
  cc_state_t   rnd;
  cc_state_t   init_blk;
  logic [31:0] blk_cnt;
  logic [31:0] blk_cnt_next;
  logic [31:0] counter;
  logic [31:0] counter_next;
  byte_pos_t   pos;
  byte_pos_t   pos_next;
  logic        ready;
  logic        ready_next;
  in_item_t    cur;
  in_item_t    cur_next;
  out_item_t   result_next;
  logic        result_valid_next;

  logic        emit;
  in_item_t    emit_src;
  logic [31:0] eff_cnt;
  byte_pos_t   eff_pos;
  logic        eff_ready;
  logic        out_free;
  byte_pos_t   rd_pos;
  logic [31:0] rd_word;
  logic [7:0]  ks_byte;

  assign eff_cnt   = head.message_start ? cfg.start_counter : counter;
  assign eff_pos   = head.message_start ? '0 : pos;
  assign eff_ready = ready && !head.message_start;
  assign out_free  = !result_valid || !result_stall;
  assign rd_pos    = (state == ST_EMIT) ? pos : eff_pos;
  assign rd_word   = work[rd_pos[5:2]];
  assign ks_byte   = rd_word[{rd_pos[1:0], 3'b000} +: 8];
  assign init_blk  = init_state(cfg, blk_cnt);

  // Four quarter rounds side by side; step[1] picks diagonals, step[0] the second half.
  always_comb begin
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    quad_t      q;
    rnd = work;
    for (int g = 0; g < 4; g++) begin
      ia = 4'(g);
      ib = step[1] ? 4'(4 + ((g + 1) & 3))  : 4'(4 + g);
      ic = step[1] ? 4'(8 + ((g + 2) & 3))  : 4'(8 + g);
      id = step[1] ? 4'(12 + ((g + 3) & 3)) : 4'(12 + g);
      q.a = work[ia];
      q.b = work[ib];
      q.c = work[ic];
      q.d = work[id];
      q = qr_half(q, step[0]);
      rnd[ia] = q.a;
      rnd[ib] = q.b;
      rnd[ic] = q.c;
      rnd[id] = q.d;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    work_next    = work;
    blk_cnt_next = blk_cnt;
    counter_next = counter;
    pos_next     = pos;
    ready_next   = ready;
    cur_next     = cur;
    pop          = 1'b0;
    emit         = 1'b0;
    emit_src     = cur;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          if (eff_ready) begin
            if (out_free) begin
              pop        = 1'b1;
              emit       = 1'b1;
              emit_src   = head;
              pos_next   = eff_pos + 1'b1;
              ready_next = (eff_pos != LAST_POS);
            end
          end else begin
            pop          = 1'b1;
            cur_next     = head;
            work_next    = init_state(cfg, eff_cnt);
            blk_cnt_next = eff_cnt;
            counter_next = eff_cnt + 32'd1;
            pos_next     = eff_pos;
            step_next    = '0;
            state_next   = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        work_next = rnd;
        step_next = step + 1'b1;
        if (step == LAST_STEP) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 16; i++) begin
          work_next[i] = work[i] + init_blk[i];
        end
        ready_next = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_src   = cur;
          pos_next   = pos + 1'b1;
          ready_next = (pos != LAST_POS);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    result_next.out_byte       = emit_src.data_byte ^ ks_byte;
    result_next.end_of_message = emit_src.message_end;
    result_valid_next          = emit ? 1'b1 : (result_valid && result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      counter      <= '0;
      pos          <= '0;
      ready        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      counter      <= counter_next;
      pos          <= pos_next;
      ready        <= ready_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    work    <= work_next;
    blk_cnt <= blk_cnt_next;
    cur     <= cur_next;
    if (emit) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_has_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ready)
    else $error("emit state without a finished keystream block");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE))
    else $error("queue popped outside idle");
  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && step == LAST_STEP) |=> (state == ST_ADD))
    else $error("round sequence did not end in final add");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (step <= LAST_STEP))
    else $error("round step out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/core/chacha20_stream_xor.sv
// Top level of the ChaCha20 stream XOR block: configuration registers, front queue, block engine.
// When a keystream block is held, a queued byte is XORed straight into the result register; when a new
//   block is needed (first byte, every 64th byte, message start) the engine loads the state, runs 40
//   steps of four parallel quarter-round halves, does the final add, then emits.
// Throughput: 1 byte per cycle out of a held block while result_stall is low; a block refill pauses the stream.
// Reset: synchronous rst clears control state and the configuration registers; no block held.
`default_nettype none
module chacha20_stream_xor import cc20_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire in_item_t              item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output out_item_t                  result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire reg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  logic     head_valid;
  in_item_t head;
  logic     pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY0:   cfg.key0          <= cfg_data;
        REG_KEY1:   cfg.key1          <= cfg_data;
        REG_KEY2:   cfg.key2          <= cfg_data;
        REG_KEY3:   cfg.key3          <= cfg_data;
        REG_NONCE0: cfg.nonce0        <= cfg_data;
        REG_NONCE1: cfg.nonce1        <= cfg_data[31:0];
        REG_START:  cfg.start_counter <= cfg_data[31:0];
        default:    cfg               <= cfg;
      endcase
    end
  end

  cc20_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  cc20_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

// File: dv/tb_chacha20_stream_xor.sv
// Self-checking testbench for chacha20_stream_xor: directed bytes, random messages, config sweeps.
module tb_chacha20_stream_xor;
  import cc20_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam reg_idx_t REG_UNUSED = 3'd7;
  localparam reg_idx_t ALL_REGS [7] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3,
                                        REG_NONCE0, REG_NONCE1, REG_START};
  localparam logic [31:0] EXPAND_W0 = 32'h61707865;
  localparam logic [31:0] EXPAND_W1 = 32'h3320646e;
  localparam logic [31:0] EXPAND_W2 = 32'h79622d32;
  localparam logic [31:0] EXPAND_W3 = 32'h6b206574;
  localparam int DRAIN_GAP    = 64;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 140;

  typedef logic [15:0][31:0] words_t;

  typedef struct packed {
    logic [1:0] seg;
    logic [7:0] data;
    logic       start;
    logic       last;
    logic       typed;
    logic [7:0] want;
  } script_row_t;

  // seg 0: zero key/nonce after reset, keystream 76 b8 e0 ad a0 f1 3d 90 ...
  localparam script_row_t SCRIPT [21] = '{
    '{2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 8'h76},
    '{2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 8'hb8},
    '{2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 8'he0},
    '{2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 8'had},
    '{2'd0, 8'hff, 1'b0, 1'b0, 1'b1, 8'h5f},
    '{2'd0, 8'hff, 1'b0, 1'b1, 1'b1, 8'h0e},
    '{2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 8'h3d},
    '{2'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h76},
    '{2'd0, 8'ha5, 1'b0, 1'b0, 1'b0, 8'h00},
    '{2'd1, 8'h4c, 1'b1, 1'b0, 1'b0, 8'h00},
    '{2'd1, 8'h61, 1'b0, 1'b0, 1'b0, 8'h00},
    '{2'd1, 8'h64, 1'b0, 1'b0, 1'b0, 8'h00},
    '{2'd1, 8'h69, 1'b0, 1'b1, 1'b0, 8'h00},
    '{2'd1, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
    '{2'd1, 8'h80, 1'b0, 1'b0, 1'b0, 8'h00},
    '{2'd1, 8'h7f, 1'b0, 1'b0, 1'b0, 8'h00},
    '{2'd2, 8'h5a, 1'b0, 1'b0, 1'b0, 8'h00},
    '{2'd2, 8'hc3, 1'b0, 1'b1, 1'b0, 8'h00},
    '{2'd2, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    '{2'd2, 8'hff, 1'b0, 1'b0, 1'b0, 8'h00},
    '{2'd2, 8'h01, 1'b0, 1'b1, 1'b0, 8'h00}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  in_item_t              item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  reg_idx_t              cfg_index = REG_KEY0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  chacha20_stream_xor dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predictor state
  logic [63:0] key_q [4] = '{default: '0};
  logic [63:0] nonce_lo = '0;
  logic [31:0] nonce_hi = '0;
  logic [31:0] start_ctr = '0;
  logic [7:0]  keystream [64];
  logic [31:0] blk_ctr = '0;
  logic [5:0]  byte_pos = '0;
  logic        have_blk = 1'b0;

  out_item_t expected_bytes [$];
  int errors = 0;
  int send_idle_pct = 24;
  int recv_stall_pct = 66;
  int n_bytes = 0;
  int n_starts = 0;
  int n_blocks = 0;
  int n_wraps = 0;
  int n_settings = 0;

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic words_t quarter(words_t w, int a, int b, int c, int d);
    w[a] += w[b]; w[d] = rotl(w[d] ^ w[a], 16);
    w[c] += w[d]; w[b] = rotl(w[b] ^ w[c], 12);
    w[a] += w[b]; w[d] = rotl(w[d] ^ w[a], 8);
    w[c] += w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic void refill_keystream();
    words_t      init;
    words_t      w;
    logic [31:0] v;
    init[0] = EXPAND_W0;
    init[1] = EXPAND_W1;
    init[2] = EXPAND_W2;
    init[3] = EXPAND_W3;
    for (int i = 0; i < 8; i++) init[4 + i] = key_q[i >> 1][(i & 1) * 32 +: 32];
    init[12] = blk_ctr;
    init[13] = nonce_lo[31:0];
    init[14] = nonce_lo[63:32];
    init[15] = nonce_hi;
    w = init;
    repeat (10) begin
      w = quarter(w, 0, 4, 8, 12);
      w = quarter(w, 1, 5, 9, 13);
      w = quarter(w, 2, 6, 10, 14);
      w = quarter(w, 3, 7, 11, 15);
      w = quarter(w, 0, 5, 10, 15);
      w = quarter(w, 1, 6, 11, 12);
      w = quarter(w, 2, 7, 8, 13);
      w = quarter(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      v = w[i] + init[i];
      for (int j = 0; j < 4; j++) keystream[i * 4 + j] = v[j * 8 +: 8];
    end
  endfunction

  function automatic out_item_t cipher_byte(in_item_t it);
    out_item_t r;
    if (it.message_start) begin
      blk_ctr  = start_ctr;
      byte_pos = '0;
      have_blk = 1'b0;
      n_starts++;
    end
    if (!have_blk) begin
      refill_keystream();
      blk_ctr++;
      have_blk = 1'b1;
      n_blocks++;
      if (blk_ctr == '0) n_wraps++;
    end
    r.out_byte       = it.data_byte ^ keystream[byte_pos];
    r.end_of_message = it.message_end;
    byte_pos++;
    if (byte_pos == '0) have_blk = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t ns: %s", $realtime, msg);
  endtask

  always @(negedge clk) result_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h", result.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (result.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    result.out_byte, want.out_byte));
        if (result.end_of_message !== want.end_of_message)
          report_mismatch($sformatf("end_of_message %b, expected %b",
                                    result.end_of_message, want.end_of_message));
      end
    end
  end

  task automatic push_byte(input in_item_t it, input logic typed, input logic [7:0] want);
    out_item_t r;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    r = cipher_byte(it);
    if (typed) r.out_byte = want;
    expected_bytes.push_back(r);
    n_bytes++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && expected_bytes.size() != 0; k++) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY0:   key_q[0]  = value;
      REG_KEY1:   key_q[1]  = value;
      REG_KEY2:   key_q[2]  = value;
      REG_KEY3:   key_q[3]  = value;
      REG_NONCE0: nonce_lo  = value;
      REG_NONCE1: nonce_hi  = value[31:0];
      REG_START:  start_ctr = value[31:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic apply_directed_cfg(input logic [1:0] seg);
    if (seg == 2'd1) begin
      cfg_write(REG_KEY0, 64'h0706050403020100);
      cfg_write(REG_KEY1, 64'h0f0e0d0c0b0a0908);
      cfg_write(REG_KEY2, 64'h1716151413121110);
      cfg_write(REG_KEY3, 64'h1f1e1d1c1b1a1918);
      cfg_write(REG_NONCE0, 64'h4a000000_00000000);
      cfg_write(REG_NONCE1, 64'hdeadbeef_00000000);
      cfg_write(REG_START, 64'hffffffff_00000001);
      cfg_write(REG_UNUSED, 64'h5555aaaa_3c3cc3c3);
    end else begin
      // mid-message: held block keeps the old key, new counter waits for a start
      cfg_write(REG_KEY0, 64'h0);
      cfg_write(REG_START, 64'h00000000_ffffffff);
    end
    cfg_release();
  endtask

  task automatic apply_phase_cfg(input int ph);
    logic [63:0] v;
    foreach (ALL_REGS[r]) begin
      if (ph == 4 && !(ALL_REGS[r] == REG_KEY2 || ALL_REGS[r] == REG_NONCE1)) continue;
      case (ph)
        1: v = '1;
        2: v = (ALL_REGS[r] == REG_START) ? 64'hffffffff_fffffffe : 64'h0;
        3: v = (ALL_REGS[r] == REG_START) ? 64'h00000000_ffffffff : rand64();
        default: v = rand64();
      endcase
      cfg_write(ALL_REGS[r], v);
    end
    if (ph != 4) cfg_write(REG_UNUSED, rand64());
    cfg_release();
  endtask

  initial begin
    in_item_t    it;
    logic [1:0]  cur_seg;
    int          left;
    logic        fresh;
    logic        first;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_seg = 2'd0;
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].seg != cur_seg) begin
        drain_results();
        apply_directed_cfg(SCRIPT[i].seg);
        cur_seg = SCRIPT[i].seg;
      end
      it.data_byte     = SCRIPT[i].data;
      it.message_start = SCRIPT[i].start;
      it.message_end   = SCRIPT[i].last;
      push_byte(it, SCRIPT[i].typed, SCRIPT[i].want);
    end

    left  = 0;
    fresh = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 24; recv_stall_pct = 66; end
        1: begin send_idle_pct = 66; recv_stall_pct = 24; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      drain_results();
      apply_phase_cfg(ph);
      // counter-wrap phases open with a long fresh message
      if (ph >= 1 && ph <= 3) begin
        left  = 130;
        fresh = 1'b1;
        first = 1'b1;
      end
      for (int n = 0; n < PHASE_BYTES; n++) begin
        if (left == 0) begin
          left  = ($urandom_range(7) == 0) ? $urandom_range(200, 1) : $urandom_range(80, 1);
          fresh = ($urandom_range(99) >= 15);
          first = 1'b1;
        end
        it.data_byte     = 8'($urandom);
        it.message_start = fresh && first;
        it.message_end   = (left == 1);
        if ($urandom_range(99) < 8) begin
          it.message_start = 1'($urandom);
          it.message_end   = 1'($urandom);
        end
        push_byte(it, 1'b0, 8'h00);
        first = 1'b0;
        left--;
      end
    end

    drain_results();
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came out", expected_bytes.size()));
    $display("Covered %0d bytes in %0d message starts, %0d keystream blocks, %0d counter wraps",
             n_bytes, n_starts, n_blocks, n_wraps);
    $display("across %0d register settings and three handshake pacing modes", n_settings);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/core/cc20_pkg.sv
rtl/core/cc20_front.sv
rtl/core/cc20_back.sv
rtl/core/chacha20_stream_xor.sv
dv/tb_chacha20_stream_xor.sv
